FILE: sv/ffha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared codes and field widths of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int ACTION_W = 2;
  localparam int SIZE_W   = 21;
  localparam int PTR_W    = 32;
  localparam int STATUS_W = 2;
  localparam int BYTES_W  = 21;
  localparam int REQ_W    = 18;   // request size in 16-byte slots, rounded up

  localparam int S_TDATA_W = 56;  // size + pointer, padded to bytes
  localparam int M_TDATA_W = 80;  // address + free + heap, padded to bytes

  localparam logic [PTR_W-1:0] HEAP_START = 32'h5000_0000;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_REINIT = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_OOM      = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

endpackage

FILE: sv/ffha_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/first_fit_heap_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit heap allocator over an address-ordered chain of 16-byte-header
// blocks kept in one header RAM, with growth, splitting and coalescing.
// ----------------------------------------------------------------------------
// channel  dir  handshake          contents
// s_*      in   s_tvalid/s_tready  tuser: action; tdata: request_size, pointer
// m_*      out  m_tvalid/m_tready  tuser: status; tdata: address, free, heap
// cfg_*    in   cfg_valid/ready    heap_cap
//
// Each header visited in a walk takes a read state and an evaluate state; accept,
// setup, growth, range check, write-back and hand-off add further states. The
// header RAM read port (one read per cycle, registered read data) sets the pace of every chain walk.
// Free and heap byte counts are kept in registers, never recounted.
// Reset is synchronous; the header RAM is not cleared.
// A finished word waits in the output register; a new word is taken meanwhile,
// and the next result holds in S_DONE until the register drains.
// Input and configuration are taken only when idle; a configuration write
// holds off the input for that cycle.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit #(
  parameter int MAX_HEAP_BYTES = 1048576,
  parameter int GROW_MIN_BYTES = 65536
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ffha_pkg::ACTION_W-1:0]   s_tuser,   // [1:0] action
  input  logic [ffha_pkg::S_TDATA_W-1:0]  s_tdata,   // [20:0] request_size, [52:21] pointer
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ffha_pkg::STATUS_W-1:0]   m_tuser,   // [1:0] status
  output logic [ffha_pkg::M_TDATA_W-1:0]  m_tdata,   // [31:0] result_address,
                                                     // [52:32] free_bytes, [73:53] heap_bytes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ffha_pkg::SIZE_W-1:0]     cfg_data   // heap_cap
);

  import ffha_pkg::*;

  localparam int DEPTH = MAX_HEAP_BYTES / 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = AW + 1;
  localparam int CW    = ((AW + 1 > REQ_W + 1) ? AW + 1 : REQ_W + 1) + 1;
  localparam int BW    = CW + 4;
  localparam logic [CW-1:0] GMIN_S   = CW'((GROW_MIN_BYTES + 15) / 16);
  localparam logic [CW-1:0] PG_ROUND = CW'(255);
  localparam logic [CW-1:0] ONE      = CW'(1);
  localparam logic [BW-1:0] MAX_B    = BW'(MAX_HEAP_BYTES);

  typedef enum logic [4:0] {
    S_IDLE, S_SETUP, S_GROW_CALC, S_GROW_APPLY, S_SETUP_WR, S_TAIL_WR,
    S_SCAN_RD, S_SCAN_EV, S_ALLOC_WR, S_FCHK, S_FWALK_RD, S_FWALK_EV,
    S_FHDR_RD, S_FHDR_EV, S_FNEXT_RD, S_FNEXT_EV, S_FWR, S_FPREV_RD,
    S_FPREV_EV, S_POST, S_DONE
  } state_t;

  state_t              state;
  action_t             act;
  logic [REQ_W-1:0]    size_s;
  logic [PTR_W-1:0]    ptr;
  logic                initialized;
  logic                grow_alloc;
  logic [SIZE_W-1:0]   heap_cap;
  logic [CW-1:0]       heap_s;
  logic [CW-1:0]       free_s;
  logic [CW-1:0]       off;
  logic [CW-1:0]       cur;
  logic [CW-1:0]       prev;
  logic                has_prev;
  logic [CW-1:0]       nxt;
  logic [CW-1:0]       old;
  logic [CW-1:0]       need;
  logic [CW-1:0]       chunk;
  logic [CW-1:0]       acc;
  logic [CW-1:0]       orig;
  logic                was_free;
  logic [CW-1:0]       wr_sz;
  logic [PTR_W-1:0]    addr_r;
  status_t             status_r;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [EW-1:0]       wdata;
  logic [AW-1:0]       raddr;
  logic [EW-1:0]       rdata;
  logic [CW-1:0]       rsz;
  logic                rfree;
  logic [BW-1:0]       cap_b;
  logic [CW-1:0]       cap_s;
  logic [CW-1:0]       grow_m;
  logic [CW-1:0]       room;
  logic [PTR_W-1:0]    pdiff;
  logic [PTR_W-1:0]    heap_b32;
  logic                ptr_ok;
  logic [SIZE_W:0]     size_sum;
  logic [BW-1:0]       free_b;
  logic [BW-1:0]       heap_b;

  ffha_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_hdr_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // decode header word and limits
  always_comb begin
    rsz      = CW'(rdata[AW-1:0]);
    rfree    = rdata[AW];
    cap_b    = (BW'(heap_cap) > MAX_B) ? MAX_B : BW'(heap_cap);
    cap_s    = CW'(cap_b >> 12) << 8;
    grow_m   = (need > GMIN_S) ? need : GMIN_S;
    room     = cap_s - heap_s;
    pdiff    = ptr - HEAP_START;
    heap_b   = {heap_s, 4'b0};
    free_b   = {free_s, 4'b0};
    heap_b32 = PTR_W'(heap_b);
    ptr_ok   = (ptr >= HEAP_START) && (pdiff >= PTR_W'(16)) && (pdiff < heap_b32) &&
               (pdiff[3:0] == 4'd0);
    size_sum = {1'b0, s_tdata[SIZE_W-1:0]} + (SIZE_W+1)'(15);
  end

  // header RAM ports per state
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    case (state)
      S_SETUP_WR: begin
        we    = (heap_s != '0);
        wdata = {1'b1, AW'(heap_s - ONE)};
      end
      S_TAIL_WR: begin
        we    = 1'b1;
        waddr = old[AW-1:0];
        wdata = {1'b1, AW'(heap_s - old - ONE)};
      end
      S_SCAN_RD:  raddr = off[AW-1:0];
      S_SCAN_EV: begin
        we    = rfree && (rsz >= CW'(size_s) + CW'(2));
        waddr = AW'(off + ONE + CW'(size_s));
        wdata = {1'b1, AW'(rsz - CW'(size_s) - ONE)};
      end
      S_ALLOC_WR: begin
        we    = 1'b1;
        waddr = off[AW-1:0];
        wdata = {1'b0, wr_sz[AW-1:0]};
      end
      S_FWALK_RD: raddr = cur[AW-1:0];
      S_FHDR_RD:  raddr = off[AW-1:0];
      S_FNEXT_RD: raddr = nxt[AW-1:0];
      S_FWR: begin
        we    = 1'b1;
        waddr = off[AW-1:0];
        wdata = {1'b1, acc[AW-1:0]};
      end
      S_FPREV_RD: raddr = prev[AW-1:0];
      S_FPREV_EV: begin
        we    = rfree;
        waddr = prev[AW-1:0];
        wdata = {1'b1, AW'(rsz + ONE + acc)};
      end
      default: ;
    endcase
  end

  assign s_tready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);

  // sequencer: state, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      initialized <= 1'b0;
      heap_s      <= '0;
      free_s      <= '0;
      heap_cap    <= SIZE_W'(1048576);
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        heap_cap <= cfg_data;
      end
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            act      <= action_t'(s_tuser);
            size_s   <= REQ_W'(size_sum >> 4);
            ptr      <= s_tdata[SIZE_W +: PTR_W];
            addr_r   <= '0;
            status_r <= ST_DONE;
            case (action_t'(s_tuser))
              ACT_ALLOC:  state <= initialized ? S_SCAN_RD : S_SETUP;
              ACT_FREE:   state <= S_FCHK;
              ACT_REINIT: state <= S_SETUP;
              default:    state <= S_POST;
            endcase
            off <= '0;
          end
        end
        // grow a fresh heap, or collapse an existing one
        S_SETUP: begin
          grow_alloc <= 1'b0;
          need       <= GMIN_S;
          state      <= (heap_s == '0) ? S_GROW_CALC : S_SETUP_WR;
        end
        S_GROW_CALC: begin
          chunk <= (grow_m + PG_ROUND) & ~PG_ROUND;
          state <= S_GROW_APPLY;
        end
        S_GROW_APPLY: begin
          old <= heap_s;
          if (heap_s >= cap_s) begin
            if (grow_alloc) begin
              status_r <= ST_OOM;
              state    <= S_DONE;
            end else begin
              state <= S_SETUP_WR;
            end
          end else begin
            heap_s <= heap_s + ((chunk > room) ? room : chunk);
            state  <= grow_alloc ? S_TAIL_WR : S_SETUP_WR;
          end
        end
        S_SETUP_WR: begin
          free_s      <= (heap_s != '0) ? heap_s - ONE : '0;
          initialized <= 1'b1;
          off         <= '0;
          state       <= (act == ACT_ALLOC) ? S_SCAN_RD : S_DONE;
        end
        S_TAIL_WR: begin
          free_s <= free_s + (heap_s - old - ONE);
          off    <= old;
          state  <= S_SCAN_RD;
        end
        // first-fit walk
        S_SCAN_RD: begin
          if (off < heap_s) begin
            state <= S_SCAN_EV;
          end else begin
            need       <= CW'(size_s) + ONE;
            grow_alloc <= 1'b1;
            state      <= S_GROW_CALC;
          end
        end
        S_SCAN_EV: begin
          if (rfree && rsz >= CW'(size_s)) begin
            if (rsz >= CW'(size_s) + CW'(2)) begin
              wr_sz  <= CW'(size_s);
              free_s <= free_s - CW'(size_s) - ONE;
            end else begin
              wr_sz  <= rsz;
              free_s <= free_s - rsz;
            end
            state <= S_ALLOC_WR;
          end else begin
            off   <= off + ONE + rsz;
            state <= S_SCAN_RD;
          end
        end
        S_ALLOC_WR: begin
          addr_r <= HEAP_START + PTR_W'({off + ONE, 4'b0});
          state  <= S_DONE;
        end
        // free: range check, then locate the block in the chain
        S_FCHK: begin
          cur      <= '0;
          has_prev <= 1'b0;
          off      <= CW'(pdiff[PTR_W-1:4] - 28'd1);
          if (ptr_ok) begin
            state <= S_FWALK_RD;
          end else begin
            status_r <= ST_BAD_FREE;
            state    <= S_POST;
          end
        end
        S_FWALK_RD: begin
          if (cur < off) begin
            state <= S_FWALK_EV;
          end else if (cur != off) begin
            status_r <= ST_BAD_FREE;
            state    <= S_POST;
          end else begin
            state <= S_FHDR_RD;
          end
        end
        S_FWALK_EV: begin
          prev     <= cur;
          has_prev <= 1'b1;
          cur      <= cur + ONE + rsz;
          state    <= S_FWALK_RD;
        end
        S_FHDR_RD: state <= S_FHDR_EV;
        S_FHDR_EV: begin
          acc      <= rsz;
          orig     <= rsz;
          was_free <= rfree;
          nxt      <= off + ONE + rsz;
          state    <= S_FNEXT_RD;
        end
        // merge forward while the next block is free
        S_FNEXT_RD: state <= (nxt < heap_s) ? S_FNEXT_EV : S_FWR;
        S_FNEXT_EV: begin
          if (rfree) begin
            acc    <= acc + ONE + rsz;
            nxt    <= nxt + ONE + rsz;
            free_s <= free_s + ONE;
            state  <= S_FNEXT_RD;
          end else begin
            state <= S_FWR;
          end
        end
        S_FWR: begin
          if (!was_free) begin
            free_s <= free_s + orig;
          end
          state <= has_prev ? S_FPREV_RD : S_POST;
        end
        S_FPREV_RD: state <= S_FPREV_EV;
        S_FPREV_EV: begin
          if (rfree) begin
            free_s <= free_s + ONE;
          end
          state <= S_POST;
        end
        S_POST: state <= initialized ? S_DONE : S_SETUP;
        // hand the result to the output register
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= status_r;
            m_tdata  <= {6'b0, heap_b[BYTES_W-1:0], free_b[BYTES_W-1:0], addr_r};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: test/first_fit_heap_allocator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit_test
// Self-checking bench for the first-fit heap allocator. A short table of
// directed words covers the opening sequence, edge sizes, bad frees and
// merges. Random traffic follows under several heap caps: mostly allocates
// and frees of live blocks, with some noise. Each result word is checked
// against the table's expected word or a behavioral model of the chain kept in this bench.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit_test;
  import ffha_pkg::*;

  localparam int MAX_BYTES = 1048576;
  localparam int GROW_MIN  = 65536;
  localparam int PAGE      = 4096;
  localparam int HDR       = 16;
  localparam logic [31:0] FREE_BIT = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] addr;
    status_t     st;
    logic [20:0] free_b;
    logic [20:0] heap_b;
  } result_t;

  localparam result_t NO_RESULT = '{32'h0, ST_DONE, 21'd0, 21'd0};

  typedef struct {
    action_t     act;
    int unsigned size;
    logic [31:0] ptr;
    bit          typed;
    result_t     want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [ACTION_W-1:0] s_tuser = '0;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [STATUS_W-1:0] m_tuser;
  logic [M_TDATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SIZE_W-1:0] cfg_data = '0;

  // chain state of the bench's own allocator
  bit [31:0]   hdr_mem[int];
  int unsigned heap_size;
  bit          heap_ready;
  int unsigned cap_reg;

  result_t     pending_q[$];
  logic [31:0] live_ptrs[$];
  int          fail_cnt;
  int          n_alloc, n_free, n_oom, n_bad, n_words;
  bit          long_hold;
  bit          sender_burst;

  always #6 clk = ~clk;

  first_fit_heap_allocator_unit i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  function automatic bit [31:0] hdr_rd(int unsigned off);
    int slot;
    slot = int'(off >> 4);
    return hdr_mem.exists(slot) ? hdr_mem[slot] : 32'd0;
  endfunction

  function automatic void hdr_wr(int unsigned off, bit [31:0] v);
    if ((off >> 4) < MAX_BYTES / 16) hdr_mem[int'(off >> 4)] = v;
  endfunction

  function automatic bit extend_heap(int unsigned need);
    int unsigned lim, chunk;
    lim = (cap_reg > MAX_BYTES ? MAX_BYTES : cap_reg) & ~(PAGE - 1);
    chunk = need < GROW_MIN ? GROW_MIN : need;
    chunk = (chunk + PAGE - 1) & ~(PAGE - 1);
    if (heap_size >= lim) chunk = 0;
    else if (chunk > lim - heap_size) chunk = lim - heap_size;
    if (chunk == 0) return 1'b0;
    heap_size += chunk;
    return 1'b1;
  endfunction

  function automatic void heap_setup();
    if (heap_size == 0) void'(extend_heap(GROW_MIN));
    if (heap_size >= HDR) hdr_wr(0, (heap_size - HDR) | FREE_BIT);
    heap_ready = 1'b1;
  endfunction

  function automatic logic [31:0] first_fit(int unsigned size);
    int unsigned off, sz, old;
    bit [31:0] h;
    forever begin
      off = 0;
      while (off < heap_size) begin
        h = hdr_rd(off);
        sz = h & ~FREE_BIT;
        if (h[31] && sz >= size) begin
          if (sz >= size + HDR + 16) begin
            hdr_wr(off + HDR + size, (sz - size - HDR) | FREE_BIT);
            sz = size;
          end
          hdr_wr(off, sz);
          return HEAP_START + off + HDR;
        end
        off += HDR + sz;
      end
      old = heap_size;
      if (!extend_heap(size + HDR)) return 32'd0;
      hdr_wr(old, (heap_size - old - HDR) | FREE_BIT);
    end
  endfunction

  function automatic status_t release_block(logic [31:0] ptr);
    int unsigned off, cur, prv, sz, nxt;
    bit has_prv;
    bit [31:0] h;
    if (ptr == 0 || ptr < HEAP_START + HDR || ptr >= HEAP_START + heap_size)
      return ST_BAD_FREE;
    off = ptr - HEAP_START - HDR;
    if (off[3:0] != 0) return ST_BAD_FREE;
    cur = 0; prv = 0; has_prv = 0;
    while (cur < off) begin
      prv = cur;
      has_prv = 1;
      cur += HDR + (hdr_rd(cur) & ~FREE_BIT);
    end
    if (cur != off) return ST_BAD_FREE;
    // merge forward through free followers, then into a free predecessor
    sz = hdr_rd(off) & ~FREE_BIT;
    nxt = off + HDR + sz;
    while (nxt < heap_size) begin
      h = hdr_rd(nxt);
      if (!h[31]) break;
      sz += HDR + (h & ~FREE_BIT);
      nxt = off + HDR + sz;
    end
    hdr_wr(off, sz | FREE_BIT);
    if (has_prv) begin
      h = hdr_rd(prv);
      if (h[31]) hdr_wr(prv, ((h & ~FREE_BIT) + HDR + sz) | FREE_BIT);
    end
    return ST_DONE;
  endfunction

  function automatic int unsigned free_total();
    int unsigned tot, off;
    bit [31:0] h;
    tot = 0; off = 0;
    while (off < heap_size) begin
      h = hdr_rd(off);
      if (h[31]) tot += h & ~FREE_BIT;
      off += HDR + (h & ~FREE_BIT);
    end
    return tot;
  endfunction

  function automatic result_t heap_step(action_t act, int unsigned size, logic [31:0] ptr);
    result_t r;
    int unsigned sz;
    r.addr = 0;
    r.st = ST_DONE;
    sz = (size + 15) & ~32'd15;
    case (act)
      ACT_ALLOC: begin
        if (!heap_ready) heap_setup();
        r.addr = first_fit(sz);
        r.st = (r.addr == 0) ? ST_OOM : ST_DONE;
      end
      ACT_FREE:   r.st = release_block(ptr);
      ACT_REINIT: heap_setup();
      default: ;
    endcase
    if (!heap_ready) heap_setup();
    r.free_b = 21'(free_total());
    r.heap_b = 21'(heap_size);
    return r;
  endfunction

  // offer one word after a random gap (none in a burst), predict it when taken
  task automatic send_word(action_t act, int unsigned size, logic [31:0] ptr,
                           bit typed = 0, result_t want = NO_RESULT);
    int gap;
    result_t r;
    gap = sender_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = act;
    s_tdata = {3'b000, ptr, size[20:0]};
    do @(posedge clk); while (!s_tready);
    r = heap_step(act, size, ptr);
    pending_q.push_back(typed ? want : r);
    n_words++;
    if (act == ACT_ALLOC) begin
      n_alloc++;
      if (r.addr != 0) live_ptrs.push_back(r.addr);
    end
    if (act == ACT_FREE) n_free++;
    if (act == ACT_REINIT) live_ptrs.delete();
    if (r.st == ST_OOM) n_oom++;
    if (r.st == ST_BAD_FREE) n_bad++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_cap(int unsigned v);
    cfg_valid = 1'b1;
    cfg_data = v[20:0];
    do @(posedge clk); while (!cfg_ready);
    cap_reg = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_word();
    int r, k;
    int unsigned sz;
    logic [31:0] p;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      k = $urandom_range(0, 99);
      if (k < 70) sz = $urandom_range(0, 512);
      else if (k < 90) sz = $urandom_range(0, 8192);
      else if (k < 98) sz = $urandom_range(0, 100000);
      else sz = $urandom_range(0, 2097151);
      send_word(ACT_ALLOC, sz, $urandom());
    end else if (r < 88) begin
      k = $urandom_range(0, 99);
      if (k < 75 && live_ptrs.size() > 0) begin
        k = $urandom_range(0, live_ptrs.size() - 1);
        p = live_ptrs[k];
        live_ptrs.delete(k);
      end else if (k < 85 && live_ptrs.size() > 0) begin
        p = live_ptrs[$urandom_range(0, live_ptrs.size() - 1)];
      end else if (k < 93) begin
        p = HEAP_START + $urandom_range(0, MAX_BYTES + 64);
      end else begin
        p = $urandom();
      end
      send_word(ACT_FREE, $urandom_range(0, 2097151), p);
    end else if (r < 95) begin
      send_word(ACT_REINIT, $urandom_range(0, 2097151), $urandom());
    end else begin
      send_word(ACT_NOP, $urandom_range(0, 2097151), $urandom());
    end
  endtask

  // compare each result word with the oldest prediction
  always @(posedge clk) begin
    result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_q.size() == 0) begin
        $error("result word with no prediction pending");
        fail_cnt++;
      end else begin
        e = pending_q.pop_front();
        if (m_tdata[31:0] !== e.addr) begin
          $error("result_address expected %h got %h", e.addr, m_tdata[31:0]);
          fail_cnt++;
        end
        if (m_tuser !== e.st) begin
          $error("status expected %0d got %0d", e.st, m_tuser);
          fail_cnt++;
        end
        if (m_tdata[52:32] !== e.free_b) begin
          $error("free_bytes expected %0d got %0d", e.free_b, m_tdata[52:32]);
          fail_cnt++;
        end
        if (m_tdata[73:53] !== e.heap_b) begin
          $error("heap_bytes expected %0d got %0d", e.heap_b, m_tdata[73:53]);
          fail_cnt++;
        end
      end
    end
  end

  // result side: random stalls, one long hold on request
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        n = 400;
        long_hold = 1'b0;
      end else begin
        n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      end
      if (n > 0) begin
        m_tready = 1'b0;
        repeat (n) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // hard stop
  initial begin
    #50ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    row_t rows[23];
    int unsigned caps[3];
    rows = '{
      '{ACT_FREE,   0,       32'h0,         1'b1,
        '{32'h0, ST_BAD_FREE, 21'd65520, 21'd65536}},
      '{ACT_ALLOC,  0,       32'h0,         1'b1,
        '{32'h5000_0010, ST_DONE, 21'd65504, 21'd65536}},
      '{ACT_REINIT, 0,       32'h0,         1'b1,
        '{32'h0, ST_DONE, 21'd65520, 21'd65536}},
      '{ACT_ALLOC,  2097151, 32'h0,         1'b1,
        '{32'h0, ST_OOM, 21'd1048544, 21'd1048576}},
      '{ACT_REINIT, 0,       32'hFFFF_FFFF, 1'b1,
        '{32'h0, ST_DONE, 21'd1048560, 21'd1048576}},
      '{ACT_ALLOC,  1,       32'h0,         1'b0, NO_RESULT},
      '{ACT_ALLOC,  17,      32'h0,         1'b0, NO_RESULT},
      '{ACT_ALLOC,  48,      32'h0,         1'b0, NO_RESULT},
      '{ACT_FREE,   0,       32'h5000_0030, 1'b0, NO_RESULT},
      '{ACT_FREE,   0,       32'h5000_0030, 1'b0, NO_RESULT},
      '{ACT_FREE,   0,       32'h5000_0018, 1'b1,
        '{32'h0, ST_BAD_FREE, 21'd1048448, 21'd1048576}},
      '{ACT_FREE,   0,       32'h5000_0008, 1'b0, NO_RESULT},
      '{ACT_FREE,   0,       32'h5000_0040, 1'b0, NO_RESULT},
      '{ACT_FREE,   0,       32'h5010_0000, 1'b0, NO_RESULT},
      '{ACT_FREE,   0,       32'hFFFF_FFFF, 1'b0, NO_RESULT},
      '{ACT_NOP,    2097151, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
      '{ACT_FREE,   0,       32'h5000_0010, 1'b0, NO_RESULT},
      '{ACT_FREE,   0,       32'h5000_0060, 1'b0, NO_RESULT},
      '{ACT_ALLOC,  1048544, 32'h0,         1'b0, NO_RESULT},
      '{ACT_ALLOC,  0,       32'h0,         1'b0, NO_RESULT},
      '{ACT_FREE,   0,       32'h5000_0010, 1'b0, NO_RESULT},
      '{ACT_ALLOC,  1048560, 32'h0,         1'b0, NO_RESULT},
      '{ACT_REINIT, 0,       32'h0,         1'b0, NO_RESULT}
    };
    caps = '{65536, 300000, 1048576};
    cap_reg = 1048576;
    heap_size = 0;
    heap_ready = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_cap(1048576);
    foreach (rows[i]) send_word(rows[i].act, rows[i].size, rows[i].ptr,
                                rows[i].typed, rows[i].want);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      write_cap(caps[ph]);
      for (int i = 0; i < 125; i++) begin
        if (i % 40 == 0) sender_burst = ($urandom_range(0, 1) == 1);
        if (ph == 0 && i == 30) long_hold = 1'b1;
        if (ph == 1 && i == 60) drain();
        random_word();
      end
      sender_burst = 0;
      drain();
    end

    $display("covered %0d words: %0d allocates, %0d frees", n_words, n_alloc, n_free);
    $display("out of memory %0d times, bad frees %0d, caps 64K to 1M", n_oom, n_bad);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
